[rtl/sg3_pkg.sv]
package sg3_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_X_DIRECTION  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int ROW_W    = 12;
   localparam int GRAD_W   = 11;
   localparam int IN_PIX_W = 8;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

   // Smallest usable image side, and the border rows/columns that emit nothing
   localparam int MIN_DIM = 3;
   localparam int BORDER  = 2;

   typedef struct packed {
      logic x_direction;
      logic [WIDTH_W-1:0] image_width;
      logic [HEIGHT_W-1:0] image_height;
   } sg3_cfg_type;

   typedef struct packed {
      logic emit;
      logic frame_end;
   } sg3_flags_type;

endpackage

[rtl/sobel_gradient_3x3_core.sv]
// Channel   Direction  Ports                                    Moves
// req       in         req_valid, req_stall, req_pixel          one pixel per request
// rsp       out        rsp_valid, rsp_stall, rsp_gradient,      zero or one gradient
//                      rsp_frame_end                            per request
// csr       in         csr_we, csr_index, csr_wdata             register write
//
// Throughput is one pixel per clock while the result is not stalled; a pixel passes
// through the pixel stage, which waits out the registered line-store read, and then
// the result register loads.
// Reset is synchronous; it clears the counters, window and valid flags and restores
// the configuration reset values.
// A stalled result holds the result register and, through it, the pixel stage;
// a new request is still taken while the result register waits if that stage is free.
module sobel_gradient_3x3_core #(
   parameter int MAX_WIDTH = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [sg3_pkg::IN_PIX_W-1:0] req_pixel,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [sg3_pkg::GRAD_W-1:0] rsp_gradient,
   output logic rsp_frame_end,
   input  logic csr_we,
   input  logic [sg3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sg3_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Only the low bits of the sample that fit the pixel width count
   localparam int PW = (PIXEL_BITS < sg3_pkg::IN_PIX_W) ? PIXEL_BITS : sg3_pkg::IN_PIX_W;
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic req_accept, out_free, advance;
   logic x_direction;
   logic [AW-1:0] addr;
   sg3_pkg::sg3_flags_type flags;

   // Pixel stage: holds the request while its line-store read completes
   logic s1_valid_ff;
   logic [PW-1:0] s1_pixel_ff;
   logic [AW-1:0] s1_addr_ff;
   sg3_pkg::sg3_flags_type s1_flags_ff;

   logic [PW-1:0] rd_upper, rd_middle;
   logic rsp_valid_ff, rsp_frame_end_ff;

   // The result register is free when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   sg3_ctrl #(
      .MAX_WIDTH(MAX_WIDTH),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept(req_accept),
      .x_direction(x_direction),
      .addr(addr),
      .flags(flags)
   );

   // Read the two previous rows at this column on acceptance; write back when the
   // pixel moves on: the middle row drops to the upper store, the new pixel
   // becomes the middle row.
   sg3_line_store #(
      .DEPTH(MAX_WIDTH),
      .AW(AW),
      .DW(PW)
   ) u_line_store (
      .clock(clock),
      .rd_en(req_accept),
      .rd_addr(addr),
      .wr_en(advance),
      .wr_addr(s1_addr_ff),
      .wr_upper(rd_middle),
      .wr_middle(s1_pixel_ff),
      .rd_upper(rd_upper),
      .rd_middle(rd_middle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel[PW-1:0];
         s1_addr_ff  <= addr;
         s1_flags_ff <= flags;
      end
   end

   // Shift the window and form the weighted sum into the result register
   sg3_window_sum #(
      .PW(PW)
   ) u_window_sum (
      .clock(clock),
      .reset(reset),
      .load(advance),
      .x_direction(x_direction),
      .top(rd_upper),
      .mid(rd_middle),
      .pix(s1_pixel_ff),
      .gradient(rsp_gradient)
   );

   // Border pixels advance the window but drop their result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff && s1_flags_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_frame_end_ff <= s1_flags_ff.frame_end;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

[rtl/sg3_ctrl.sv]
module sg3_ctrl #(
   parameter int MAX_WIDTH = 1024,
   parameter int AW = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [sg3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sg3_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic accept,
   output logic x_direction,
   output logic [AW-1:0] addr,
   output sg3_pkg::sg3_flags_type flags
);

   localparam int CW = ($clog2(MAX_WIDTH + 1) > sg3_pkg::WIDTH_W) ?
                       $clog2(MAX_WIDTH + 1) : sg3_pkg::WIDTH_W;
   localparam logic [CW-1:0] W_MIN = CW'(sg3_pkg::MIN_DIM);
   localparam logic [CW-1:0] W_MAX = CW'(MAX_WIDTH);
   localparam logic [sg3_pkg::HEIGHT_W-1:0] H_MIN = sg3_pkg::HEIGHT_W'(sg3_pkg::MIN_DIM);

   sg3_pkg::sg3_cfg_type cfg_ff;
   logic [AW-1:0] col_ff, col_in;
   logic [sg3_pkg::ROW_W-1:0] row_ff, row_in;

   logic [CW-1:0] width_ext, w_eff, col_ext;
   logic [sg3_pkg::HEIGHT_W-1:0] h_eff, row_ext;
   logic last_col, last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_direction  <= 1'b1;
         cfg_ff.image_width  <= sg3_pkg::WIDTH_RESET;
         cfg_ff.image_height <= sg3_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sg3_pkg::CSR_X_DIRECTION:  cfg_ff.x_direction <= csr_wdata[0];
            sg3_pkg::CSR_IMAGE_WIDTH:  cfg_ff.image_width <= csr_wdata[sg3_pkg::WIDTH_W-1:0];
            sg3_pkg::CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the sizes into the supported range
   always_comb begin
      width_ext = CW'(cfg_ff.image_width);
      if (width_ext < W_MIN)
         w_eff = W_MIN;
      else if (width_ext > W_MAX)
         w_eff = W_MAX;
      else
         w_eff = width_ext;

      if (cfg_ff.image_height < H_MIN)
         h_eff = H_MIN;
      else if (cfg_ff.image_height > sg3_pkg::HEIGHT_LIMIT)
         h_eff = sg3_pkg::HEIGHT_LIMIT;
      else
         h_eff = cfg_ff.image_height;
   end

   always_comb begin
      col_ext = CW'(col_ff);
      row_ext = sg3_pkg::HEIGHT_W'(row_ff);
      // a count left past the end by a size change addresses the last column
      if (col_ext >= w_eff)
         addr = AW'(w_eff - CW'(1));
      else
         addr = col_ff;
      last_col = col_ext >= (w_eff - CW'(1));
      last_row = row_ext >= (h_eff - sg3_pkg::HEIGHT_W'(1));
      flags.emit = (row_ff >= sg3_pkg::ROW_W'(sg3_pkg::BORDER)) &&
                   (col_ff >= AW'(sg3_pkg::BORDER));
      flags.frame_end = last_col && last_row;

      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + sg3_pkg::ROW_W'(1);
      end else begin
         col_in = col_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign x_direction = cfg_ff.x_direction;

endmodule

[rtl/sg3_line_store.sv]
module sg3_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW = 10,
   parameter int DW = 8
) (
   input  logic clock,
   input  logic rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_upper,
   input  logic [DW-1:0] wr_middle,
   output logic [DW-1:0] rd_upper,
   output logic [DW-1:0] rd_middle
);

   logic [DW-1:0] upper_mem [DEPTH];
   logic [DW-1:0] middle_mem [DEPTH];
   logic [DW-1:0] rd_upper_ff, rd_middle_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
   end

   // Read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_upper_ff  <= upper_mem[rd_addr];
         rd_middle_ff <= middle_mem[rd_addr];
      end
   end

   assign rd_upper  = rd_upper_ff;
   assign rd_middle = rd_middle_ff;

endmodule

[rtl/sg3_window_sum.sv]
module sg3_window_sum #(
   parameter int PW = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic x_direction,
   input  logic [PW-1:0] top,
   input  logic [PW-1:0] mid,
   input  logic [PW-1:0] pix,
   output logic signed [sg3_pkg::GRAD_W-1:0] gradient
);

   localparam int SW  = PW + 3;
   localparam int EXW = (SW > sg3_pkg::GRAD_W) ? SW : sg3_pkg::GRAD_W;
   localparam logic signed [EXW-1:0] G_MAX = EXW'((2 ** (sg3_pkg::GRAD_W - 1)) - 1);
   localparam logic signed [EXW-1:0] G_MIN = -EXW'(2 ** (sg3_pkg::GRAD_W - 1));

   // [row][col], row 0 top, col 0 left
   logic [PW-1:0] win_ff [3][3];
   logic [PW-1:0] win_in [3][3];
   logic [SW-1:0] pos_sum, neg_sum;
   logic signed [EXW-1:0] diff;
   logic signed [sg3_pkg::GRAD_W-1:0] grad_in, grad_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = top;
      win_in[1][2] = mid;
      win_in[2][2] = pix;

      if (x_direction) begin
         pos_sum = SW'(win_in[0][0]) + SW'({win_in[1][0], 1'b0}) + SW'(win_in[2][0]);
         neg_sum = SW'(win_in[0][2]) + SW'({win_in[1][2], 1'b0}) + SW'(win_in[2][2]);
      end else begin
         pos_sum = SW'(win_in[0][0]) + SW'({win_in[0][1], 1'b0}) + SW'(win_in[0][2]);
         neg_sum = SW'(win_in[2][0]) + SW'({win_in[2][1], 1'b0}) + SW'(win_in[2][2]);
      end
      diff = EXW'(signed'(pos_sum - neg_sum));

      // saturate into the result width
      if (diff > G_MAX)
         grad_in = sg3_pkg::GRAD_W'(G_MAX);
      else if (diff < G_MIN)
         grad_in = sg3_pkg::GRAD_W'(G_MIN);
      else
         grad_in = sg3_pkg::GRAD_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               win_ff[r][c] <= '0;
      end else if (load) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load)
         grad_ff <= grad_in;
   end

   assign gradient = grad_ff;

endmodule
